// ----- hdl/u2u_pkg.sv -----
// ============================================================================
// UTF-16 to UTF-8 transcoder package
// Shared constants, queue entry type and the UTF-8 encoder function.
// ============================================================================
package u2u_pkg;

    localparam int MAX_CAPACITY = 4096;
    localparam int CAP_W        = 13;
    localparam int UNIT_W       = 16;
    localparam int CP_W         = 21;
    localparam int SEQ_BYTES    = 6;
    localparam int CNT_W        = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd766;
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_CAPACITY);
    localparam logic [CAP_W:0]   ROOM_NEED = 14'd4;

    // High surrogate tag is 110110, low surrogate tag is 110111
    localparam logic [5:0]    SURR_HI_TAG = 6'b110110;
    localparam logic [5:0]    SURR_LO_TAG = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t [3:0]      b;
        logic [CNT_W-1:0] n;
    } enc_t;

    typedef struct packed {
        byte_t [SEQ_BYTES-1:0] bytes;
        logic [CNT_W-1:0]      nbytes;
        logic                  is_end;
        logic                  trunc;
    } ent_t;

    function automatic enc_t utf8_encode(input logic [CP_W-1:0] cp);
        enc_t e;
        e = '0;
        if (cp < 21'h80) begin
            e.b[0] = {1'b0, cp[6:0]};
            e.n    = 3'd1;
        end else if (cp < 21'h800) begin
            e.b[0] = LEAD2 | {3'b000, cp[10:6]};
            e.b[1] = CONT  | {2'b00, cp[5:0]};
            e.n    = 3'd2;
        end else if (cp < SUPP_BASE) begin
            e.b[0] = LEAD3 | {4'b0000, cp[15:12]};
            e.b[1] = CONT  | {2'b00, cp[11:6]};
            e.b[2] = CONT  | {2'b00, cp[5:0]};
            e.n    = 3'd3;
        end else begin
            e.b[0] = LEAD4 | {5'b00000, cp[20:18]};
            e.b[1] = CONT  | {2'b00, cp[17:12]};
            e.b[2] = CONT  | {2'b00, cp[11:6]};
            e.b[3] = CONT  | {2'b00, cp[5:0]};
            e.n    = 3'd4;
        end
        return e;
    endfunction

endpackage

// ----- hdl/u2u_front.sv -----
// ============================================================================
// UTF-16 to UTF-8 front end
// Accepts code units, tracks surrogate and capacity state, builds byte runs.
// ============================================================================
module u2u_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [u2u_pkg::UNIT_W-1:0] in_unit,
    input  logic                     in_end,
    input  logic                     q_ready,
    output logic                     in_ready,
    output logic                     push,
    output u2u_pkg::ent_t            push_ent,
    input  logic                     cfg_valid,
    input  logic [u2u_pkg::CAP_W-1:0] cfg_data,
    output logic                     cfg_ready
);
    import u2u_pkg::*;

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [9:0]       held_bits_reg, held_bits_next;
    logic             held_reg, held_next;
    logic [CAP_W-1:0] bw_reg, bw_next;
    logic             full_reg, full_next;

    logic             accept;
    logic             is_hi, is_lo;
    logic [CAP_W-1:0] cap_eff;
    logic [CAP_W:0]   chk_base;
    logic             no_room;
    enc_t             enc_flush, enc_pair, enc_unit;
    ent_t             ent;
    logic [CNT_W-1:0] data_bytes;

    assign cfg_ready = 1'b1;
    assign in_ready  = q_ready;
    assign accept    = in_valid && in_ready;

    assign is_hi   = (in_unit[15:10] == SURR_HI_TAG);
    assign is_lo   = (in_unit[15:10] == SURR_LO_TAG);
    assign cap_eff = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;

    assign enc_flush = utf8_encode({5'b00000, SURR_HI_TAG, held_bits_reg});
    assign enc_pair  = utf8_encode({1'b0, held_bits_reg, in_unit[9:0]} + SUPP_BASE);
    assign enc_unit  = utf8_encode({5'b00000, in_unit});

    // A flushed high surrogate counts toward the room check of the new unit
    assign chk_base = {1'b0, bw_reg} + ((held_reg && !in_end) ? 14'd3 : 14'd0);
    assign no_room  = full_reg || ((chk_base + ROOM_NEED) >= {1'b0, cap_eff});

    always_comb
    begin
        ent            = '0;
        ent.trunc      = full_reg;
        ent.is_end     = in_end;
        data_bytes     = '0;
        held_next      = held_reg;
        held_bits_next = held_bits_reg;
        full_next      = full_reg;
        if (in_end) begin
            if (held_reg) begin
                ent.bytes[2:0] = enc_flush.b[2:0];
                ent.bytes[3]   = 8'h00;
                ent.nbytes     = 3'd4;
            end else begin
                ent.bytes[0] = 8'h00;
                ent.nbytes   = 3'd1;
            end
            held_next      = 1'b0;
            held_bits_next = '0;
            full_next      = 1'b0;
        end else if (held_reg && is_lo) begin
            ent.bytes[3:0] = enc_pair.b;
            ent.nbytes     = enc_pair.n;
            data_bytes     = enc_pair.n;
            held_next      = 1'b0;
        end else begin
            if (held_reg) begin
                ent.bytes[2:0] = enc_flush.b[2:0];
            end
            held_next = 1'b0;
            if (no_room) begin
                full_next = 1'b1;
            end else if (is_hi) begin
                held_next      = 1'b1;
                held_bits_next = in_unit[9:0];
            end else if (held_reg) begin
                ent.bytes[5:3] = enc_unit.b[2:0];
            end else begin
                ent.bytes[2:0] = enc_unit.b[2:0];
            end
            ent.nbytes = (held_reg ? 3'd3 : 3'd0)
                       + ((!no_room && !is_hi) ? enc_unit.n : 3'd0);
            data_bytes = ent.nbytes;
        end
    end

    assign push     = accept && (ent.nbytes != '0);
    assign push_ent = ent;

    always_comb
    begin
        bw_next  = bw_reg;
        cap_next = cap_reg;
        if (accept) begin
            bw_next = in_end ? '0 : (bw_reg + CAP_W'(data_bytes));
        end
        if (cfg_valid && cfg_ready) begin
            cap_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg       <= CAP_RESET;
            held_reg      <= 1'b0;
            held_bits_reg <= '0;
            bw_reg        <= '0;
            full_reg      <= 1'b0;
        end else begin
            cap_reg <= cap_next;
            bw_reg  <= bw_next;
            if (accept) begin
                held_reg      <= held_next;
                held_bits_reg <= held_bits_next;
                full_reg      <= full_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_held_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> !full_reg)
        else $error("high surrogate held while string is marked full");
    a_bw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bw_reg < CAP_LIMIT)
        else $error("byte count beyond maximum capacity");
    a_trunc_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !push_ent.is_end) |-> !push_ent.trunc)
        else $error("truncation flag on a data run");
`endif

endmodule

// ----- hdl/u2u_queue.sv -----
// ============================================================================
// UTF-16 to UTF-8 run queue
// Short FIFO of byte runs between the front end and the serializer.
// ============================================================================
module u2u_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  u2u_pkg::ent_t push_ent,
    output logic          push_ready,
    input  logic          pop,
    output logic          head_valid,
    output u2u_pkg::ent_t head_ent
);
    import u2u_pkg::*;

    ent_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_ent   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !push_ready) |=> (cnt_reg == Q_CNT_W'(Q_DEPTH)) || pop)
        else $error("push into a full queue");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");
`endif

endmodule

// ----- hdl/u2u_back.sv -----
// ============================================================================
// UTF-16 to UTF-8 serializer
// Pops byte runs and drives them out one byte per transfer.
// ============================================================================
module u2u_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  u2u_pkg::ent_t head_ent,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic          out_trunc
);
    import u2u_pkg::*;

    ent_t             ent_reg;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             vld_reg, vld_next;
    logic [7:0]       byte_reg;
    logic             last_reg, trunc_reg;
    logic             out_free, take, run_done;

    assign out_free = !vld_reg || out_ready;
    assign take     = busy_reg && out_free;
    assign run_done = (idx_reg == (ent_reg.nbytes - 1'b1));
    assign pop      = head_valid && (!busy_reg || (take && run_done));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        vld_next  = vld_reg;
        if (pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (take) begin
            busy_next = !run_done;
            idx_next  = idx_reg + 1'b1;
        end
        if (take) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            ent_reg <= head_ent;
        end
        if (take) begin
            byte_reg  <= ent_reg.bytes[idx_reg];
            last_reg  <= ent_reg.is_end && run_done;
            trunc_reg <= ent_reg.trunc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            vld_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            vld_reg  <= vld_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_trunc = trunc_reg;

endmodule

// ----- hdl/utf16_to_utf8_transcoder.sv -----
// ============================================================================
// UTF-16 to UTF-8 transcoder
// Each item's bytes pass the run queue, the serializer's run register and
// its output byte register. Throughput: one output byte per cycle while the
// output is ready and runs are queued; an item of n bytes takes n transfers,
// one to three per basic-plane unit. The byte serializer sets this rate.
// Reset: asynchronous, active low; clears surrogate, drop, count, queue and
// serializer state and loads the capacity register with 766.
// ============================================================================
module utf16_to_utf8_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: tdata = code_unit[15:0]; tlast = end_of_string
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    // Output stream: tdata = out_byte[7:0]; tlast = last; tuser = truncated
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic        m_tuser,
    // Capacity register write channel: out_capacity[12:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);
    import u2u_pkg::*;

    // Front end to queue
    logic q_push;
    logic q_push_ready;
    ent_t q_push_ent;

    // Queue to serializer
    logic q_head_valid;
    logic q_pop;
    ent_t q_head_ent;

    // Front end: classify each unit, pair surrogates, check the room left and
    // build the item's whole byte run in the cycle it is accepted. Items that
    // only hold a high surrogate or get dropped push no bytes of their own.
    u2u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_unit   (s_tdata),
        .in_end    (s_tlast),
        .q_ready   (q_push_ready),
        .in_ready  (s_tready),
        .push      (q_push),
        .push_ent  (q_push_ent),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready)
    );

    // Two-entry run queue: lets the front take new units while the
    // serializer still drains earlier runs.
    u2u_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ent   (q_push_ent),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_ent   (q_head_ent)
    );

    // Serializer: advance one byte per output transfer, pop the next run
    // in the same cycle the current one finishes.
    u2u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_ent   (q_head_ent),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_trunc  (m_tuser)
    );

endmodule

// ----- verif/tb_utf16_to_utf8_transcoder.sv -----
`timescale 1ns / 1ps
// ============================================================================
// UTF-16 to UTF-8 transcoder testbench
// Streams code units and end-of-string items into the transcoder and checks
// every UTF-8 byte against a behavioral predictor. Covers encoding ranges,
// surrogate pairing, capacity truncation, output backpressure and random
// strings under several capacity settings.
// ============================================================================
module tb_utf16_to_utf8_transcoder;

    localparam int          CLK_HALF      = 10;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          IDLE_LIMIT    = 4000;
    localparam int          RANDOM_ITEMS  = 300;
    localparam int          REPORT_MAX    = 10;
    localparam logic [15:0] HIGH_BASE     = 16'hD800;
    localparam logic [15:0] LOW_BASE      = 16'hDC00;
    localparam logic [15:0] SURR_END      = 16'hE000;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } utf8_byte_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data  = '0;

    // Predictor state: mirrors the surrogate holder, byte count and drop flag
    logic [9:0]  pend_hi_bits = '0;
    logic        pend_hi      = 1'b0;
    logic [12:0] out_count    = '0;
    logic        dropped      = 1'b0;
    logic [12:0] capacity     = u2u_pkg::CAP_RESET;

    utf8_byte_t  expected_bytes[$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          idle_cycles = 0;

    // Sender burst shaping
    bit          gaps_on    = 1'b1;
    int          burst_left = 0;

    // Receiver stall pattern; a change of hold_token starts a long hold-off
    int          hold_token = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    int          rx_mode    = 0;
    int          phase_left = 0;

    utf16_to_utf8_transcoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // code_unit[15:0]
        .s_tlast   (s_tlast),    // end_of_string
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // out_byte[7:0]
        .m_tlast   (m_tlast),    // last
        .m_tuser   (m_tuser),    // truncated
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)    // out_capacity[12:0]
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Queue one byte; the truncated flag reflects the drop state right now
    function automatic void push_byte(input logic [7:0] b, input logic is_last);
        expected_bytes.push_back('{data: b, last: is_last, trunc: dropped});
        if (!is_last)
            out_count = out_count + 13'd1;
    endfunction

    function automatic void push_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            push_byte({1'b0, cp[6:0]}, 1'b0);
        end
        else if (cp < 21'h800) begin
            push_byte(8'hC0 | {3'b000, cp[10:6]}, 1'b0);
            push_byte(8'h80 | {2'b00, cp[5:0]}, 1'b0);
        end
        else if (cp < SUPP_BASE) begin
            push_byte(8'hE0 | {4'b0000, cp[15:12]}, 1'b0);
            push_byte(8'h80 | {2'b00, cp[11:6]}, 1'b0);
            push_byte(8'h80 | {2'b00, cp[5:0]}, 1'b0);
        end
        else begin
            push_byte(8'hF0 | {5'b00000, cp[20:18]}, 1'b0);
            push_byte(8'h80 | {2'b00, cp[17:12]}, 1'b0);
            push_byte(8'h80 | {2'b00, cp[11:6]}, 1'b0);
            push_byte(8'h80 | {2'b00, cp[5:0]}, 1'b0);
        end
    endfunction

    // Work out the bytes that one accepted input transfer produces
    function automatic void predict_transfer(input logic [15:0] unit, input logic eos);
        int eff_cap;
        logic [20:0] held_cp;
        eff_cap = (int'(capacity) > u2u_pkg::MAX_CAPACITY) ?
                  u2u_pkg::MAX_CAPACITY : int'(capacity);
        held_cp = 21'(HIGH_BASE | {6'b000000, pend_hi_bits});
        if (eos) begin
            // Flush a held high surrogate, then the terminator; clear string state
            if (pend_hi)
                push_code_point(held_cp);
            pend_hi = 1'b0;
            push_byte(8'h00, 1'b1);
            pend_hi_bits = '0;
            out_count    = '0;
            dropped      = 1'b0;
            return;
        end
        if (pend_hi) begin
            pend_hi = 1'b0;
            // A completing low surrogate skips the capacity check
            if (unit >= LOW_BASE && unit < SURR_END) begin
                push_code_point({1'b0, pend_hi_bits, unit[9:0]} + SUPP_BASE);
                return;
            end
            push_code_point(held_cp);
        end
        if (dropped || int'(out_count) + 4 >= eff_cap) begin
            dropped = 1'b1;
            return;
        end
        if (unit >= HIGH_BASE && unit < LOW_BASE) begin
            pend_hi_bits = unit[9:0];
            pend_hi      = 1'b1;
            return;
        end
        push_code_point({5'b00000, unit});
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one item; insert a random gap when a burst runs out. Hold valid
    // high across back-to-back items.
    task automatic send_item(input logic [15:0] unit, input logic eos);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_tdata  <= unit;
        s_tlast  <= eos;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_transfer(unit, eos);
        items_sent++;
    endtask

    // Drop valid and wait until every expected byte is out, then let the
    // block finish any work that produces no byte
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [12:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity = value;
    endtask

    function automatic logic [15:0] pick_range(input int lo, input int hi);
        return 16'($urandom_range(hi, lo));
    endfunction

    // One string of mostly well-formed text, with lone surrogates mixed in
    task automatic send_random_string(input int len);
        int kind;
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: send_item(pick_range(0, 16'h7F), 1'b0);
                2:    send_item(pick_range(16'h80, 16'h7FF), 1'b0);
                3:    send_item(pick_range(16'h800, 16'hD7FF), 1'b0);
                4:    send_item(pick_range(16'hE000, 16'hFFFF), 1'b0);
                5, 6:
                begin
                    send_item(pick_range(16'hD800, 16'hDBFF), 1'b0);
                    send_item(pick_range(16'hDC00, 16'hDFFF), 1'b0);
                end
                7:    send_item(pick_range(16'hD800, 16'hDBFF), 1'b0);
                8:    send_item(pick_range(16'hDC00, 16'hDFFF), 1'b0);
                default: send_item(pick_range(0, 16'hFFFF), 1'b0);
            endcase
        end
        // The unit field of an end item is ignored; give it random content
        send_item(pick_range(0, 16'hFFFF), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Encoding boundaries, surrogate pairs, lone surrogates and end flush at
    // the reset capacity
    task automatic test_encoding_ranges();
        send_item(16'h0000, 1'b0);    // zero unit is an ordinary byte
        send_item(16'h007F, 1'b0);
        send_item(16'h0080, 1'b0);
        send_item(16'h07FF, 1'b0);
        send_item(16'h0800, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hD800, 1'b0);    // lowest pair
        send_item(16'hDC00, 1'b0);
        send_item(16'hDBFF, 1'b0);    // highest pair
        send_item(16'hDFFF, 1'b0);
        send_item(16'hDA00, 1'b0);    // lone high, broken by a plain unit
        send_item(16'h0041, 1'b0);
        send_item(16'hDC00, 1'b0);    // lone low
        send_item(16'hDB00, 1'b0);    // high held up to the end item
        send_item(16'hFFFF, 1'b1);
        settle();
    endtask

    // Tiny buffers: drop on full, flush near the limit and a pair completing
    // past the check
    task automatic test_capacity_limits();
        write_capacity(13'd4);
        send_item(16'h0041, 1'b0);
        send_item(16'h0000, 1'b1);
        settle();

        write_capacity(13'd5);
        send_item(16'h0041, 1'b0);
        send_item(16'h0042, 1'b0);
        send_item(16'h0000, 1'b1);
        settle();

        write_capacity(13'd8);
        send_item(16'h0041, 1'b0);
        send_item(16'h0042, 1'b0);
        send_item(16'hD800, 1'b0);
        send_item(16'h0043, 1'b0);
        send_item(16'h0000, 1'b1);
        settle();

        write_capacity(13'd9);
        send_item(16'h0041, 1'b0);
        send_item(16'hD800, 1'b0);
        send_item(16'hDC00, 1'b0);
        send_item(16'h0042, 1'b0);
        send_item(16'h0000, 1'b1);
        settle();
    endtask

    // Hold the output off for a long stretch while input keeps coming, so
    // the block fills up and stalls its input
    task automatic test_output_backpressure();
        write_capacity(13'd4096);
        gaps_on = 1'b0;
        hold_token <= hold_token + 1;
        for (int i = 0; i < 60; i++)
            send_item(pick_range(16'hE000, 16'hFFFF), 1'b0);
        send_item(16'h0000, 1'b1);
        gaps_on = 1'b1;
        settle();
    endtask

    task automatic test_random_strings();
        int          base;
        int          phase;
        logic [12:0] cap;
        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            case (phase)
                0: cap = 13'd4096;
                1: cap = 13'd5;
                2: cap = u2u_pkg::CAP_RESET;
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: cap = 13'($urandom_range(5, 16));
                        1: cap = 13'($urandom_range(17, 80));
                        2: cap = 13'($urandom_range(81, 4096));
                        default: cap = 13'd4096;
                    endcase
                end
            endcase
            write_capacity(cap);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 5))
                send_random_string($urandom_range(0, 24));
            settle();
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encoding_ranges();
        test_capacity_limits();
        test_output_backpressure();
        test_random_strings();
        settle();
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("[utf16_to_utf8_transcoder] OK");
        else
            $display("[utf16_to_utf8_transcoder] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall phases, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else begin
            if (phase_left == 0) begin
                phase_left <= $urandom_range(4, 60);
                rx_mode    <= $urandom_range(0, 3);
            end
            else begin
                phase_left <= phase_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;                           // no stalls
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);    // heavy stall
                default: m_tready <= (phase_left % 3 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each output transfer with the oldest expected byte
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        utf8_byte_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected byte: data %h last %b trunc %b",
                             m_tdata, m_tlast, m_tuser);
            end
            else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last ||
                    m_tuser !== want.trunc) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("byte mismatch: expected %h/%b/%b got %h/%b/%b",
                                 want.data, want.last, want.trunc,
                                 m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[utf16_to_utf8_transcoder] ERROR");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
hdl/u2u_pkg.sv
hdl/u2u_front.sv
hdl/u2u_queue.sv
hdl/u2u_back.sv
hdl/utf16_to_utf8_transcoder.sv
verif/tb_utf16_to_utf8_transcoder.sv
